@@ hdl/ncrs_pkg.sv @@
package ncrs_pkg;

  // Configuration register map
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int TOL_W      = 16;
  localparam int ITER_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 4'd1;

  localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd66;
  localparam logic [ITER_W-1:0] MAXIT_RESET = 8'd50;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_CONVERGED  = 2'd0,
    STAT_LIMIT      = 2'd1,
    STAT_ZERO_SLOPE = 2'd2,
    STAT_OVERFLOW   = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_LD,
    S_SQ_MUL,
    S_SQ_FIN,
    S_CU_LD,
    S_CU_MUL,
    S_CU_FIN,
    S_CU_SUB1,
    S_CU_SUB2,
    S_CU_SUB3,
    S_SL_ADD1,
    S_SL_ADD2,
    S_SL_SUB,
    S_SL_CHK,
    S_DIV,
    S_DIV_FIN,
    S_NXT,
    S_EV_CHK,
    S_TOL_MUL,
    S_TOL_CHK,
    S_DONE
  } state_t;

endpackage

@@ hdl/newton_cubic_root_solver.sv @@
// Channel  Dir  Handshake                    Payload
// guess    in   guess_valid / guess_stall    initial_guess (signed fixed point)
// result   out  result_valid / result_stall  root, residual, iterations, status
// cfg      in   cfg_valid / cfg_ready        cfg_index, cfg_data
//
// The restoring divider, one quotient bit per cycle, sets most of each iteration.
// Reset is synchronous: it idles the sequencer, drops result_valid and loads
// tolerance 66 and max_iterations 50. guess_stall is high while a search runs.
// A finished result waits in the output register under result_stall while the
// next guess is already taken; cfg_ready is always high.
module newton_cubic_root_solver import ncrs_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        guess_valid,
  output logic                        guess_stall,
  input  logic signed [31:0]          initial_guess,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [31:0]          root,
  output logic signed [31:0]          residual,
  output logic [ITER_W-1:0]           iterations,
  output logic [1:0]                  status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int W    = WORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = W + F;
  localparam int PW   = 2 * W;
  localparam int NCH  = (W + 15) / 16;
  localparam int MBW  = NCH * 16;
  localparam int OPW  = (W > F + 4) ? W : F + 4;
  localparam int GW   = (W > 32) ? W : 32;
  localparam int CNTW = $clog2(DW);

  localparam logic signed [W-1:0]   WMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]   WMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]          WMAX_U = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]          CAP_U  = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [OPW:0]   SMAX   = (OPW+1)'(WMAX);
  localparam logic signed [OPW:0]   SMIN   = (OPW+1)'(WMIN);
  localparam logic signed [OPW-1:0] FIVE_Q = OPW'(5) << F;
  localparam logic signed [GW-1:0]  GMAX   = GW'(WMAX);
  localparam logic signed [GW-1:0]  GMIN   = GW'(WMIN);
  localparam logic signed [GW-1:0]  OMAX   = GW'(32'sh7FFF_FFFF);
  localparam logic signed [GW-1:0]  OMIN   = GW'(32'sh8000_0000);

  // Magnitude of a signed word
  function automatic logic [W-1:0] magw(input logic signed [W-1:0] v);
    logic [W-1:0] u;
    u = v;
    if (u[W-1]) u = ~u + W'(1);
    return u;
  endfunction

  // Saturate a magnitude to the signed word; top bit flags overflow
  function automatic logic [W:0] sat_mag(input logic [PW-1:0] m, input logic neg);
    logic [PW-1:0] lim;
    logic [W-1:0]  v;
    logic          o;
    lim = neg ? PW'(CAP_U) : PW'(WMAX_U);
    o   = m > lim;
    v   = o ? lim[W-1:0] : m[W-1:0];
    if (neg) v = ~v + W'(1);
    return {o, v};
  endfunction

  // Clamp a 32-bit guess into the word
  function automatic logic signed [W-1:0] clamp_in(input logic signed [31:0] g);
    logic signed [GW-1:0] e;
    e = GW'(g);
    if (e > GMAX) return WMAX;
    if (e < GMIN) return WMIN;
    return W'(e);
  endfunction

  // Clamp a word into the 32-bit output range
  function automatic logic signed [31:0] clamp_out(input logic signed [W-1:0] v);
    logic signed [GW-1:0] e;
    e = GW'(v);
    if (e > OMAX) return 32'sh7FFF_FFFF;
    if (e < OMIN) return 32'sh8000_0000;
    return 32'(e);
  endfunction

  state_t state, state_next;

  // Configuration registers
  logic [TOL_W-1:0]  tolerance;
  logic [ITER_W-1:0] max_iterations;

  // Search registers
  logic signed [W-1:0] cur, nxt, res, x2, tacc;
  logic [W:0]          dmag;
  logic [ITER_W-1:0]   iter;
  logic                ovf, first;
  status_t             fin_status;

  // Shared multiply / divide unit
  logic [W-1:0]    ma;
  logic [MBW-1:0]  mb;
  logic [PW-1:0]   acc;
  logic [W-1:0]    rem;
  logic [CNTW-1:0] cnt;
  logic            mneg;

  logic [W+15:0]   pp;
  logic [PW-1:0]   mul_acc;
  logic [W-1:0]    rem_sh, rem_next;
  logic            qbit;
  logic [PW-1:0]   conv_in;
  logic [W:0]      conv_out;
  logic            conv_hit;
  logic            out_free;

  // Shared saturating adder
  logic signed [OPW-1:0] add_a, add_b;
  logic                  add_sub;
  logic signed [OPW:0]   sum_raw;
  logic [OPW:0]          sum_abs;
  logic signed [W-1:0]   add_val;
  logic                  add_ovf;
  logic [W:0]            add_mag;

  // Multiply step: one 16-bit digit of mb per cycle, MSB first
  always_comb begin
    pp      = ma * mb[MBW-1 -: 16];
    mul_acc = PW'({acc, 16'h0}) + PW'(pp);
  end

  // Divide step: one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem[W-2:0], acc[DW-1]};
    qbit     = rem_sh >= ma;
    rem_next = qbit ? rem_sh - ma : rem_sh;
  end

  // Saturate a product or quotient back to the word
  always_comb begin
    conv_in  = (state == S_DIV_FIN) ? acc : acc >> F;
    conv_out = sat_mag(conv_in, mneg);
  end

  // Relative step test: |nxt - cur| * 65536 < tolerance * |nxt|
  assign conv_hit = PW'({dmag, 16'h0}) < acc;
  assign out_free = !result_valid || !result_stall;

  // Adder operand selection
  always_comb begin
    unique case (state)
      S_CU_SUB1, S_CU_SUB2: begin
        add_a = OPW'(tacc); add_b = OPW'(x2); add_sub = 1'b1;
      end
      S_CU_SUB3: begin
        add_a = OPW'(tacc); add_b = FIVE_Q; add_sub = 1'b1;
      end
      S_SL_ADD1: begin
        add_a = OPW'(x2); add_b = OPW'(x2); add_sub = 1'b0;
      end
      S_SL_ADD2: begin
        add_a = OPW'(tacc); add_b = OPW'(x2); add_sub = 1'b0;
      end
      S_SL_SUB: begin
        add_a = OPW'(tacc); add_b = OPW'(cur); add_sub = 1'b1;
      end
      S_NXT: begin
        add_a = OPW'(cur); add_b = OPW'(tacc); add_sub = 1'b1;
      end
      S_EV_CHK: begin
        add_a = OPW'(nxt); add_b = OPW'(cur); add_sub = 1'b1;
      end
      default: begin
        add_a = OPW'(tacc); add_b = OPW'(x2); add_sub = 1'b0;
      end
    endcase
  end

  // Add or subtract, then clamp to the word
  always_comb begin
    sum_raw = add_sub ? (OPW+1)'(add_a) - (OPW+1)'(add_b)
                      : (OPW+1)'(add_a) + (OPW+1)'(add_b);
    sum_abs = sum_raw[OPW] ? ~sum_raw + (OPW+1)'(1) : sum_raw;
    add_mag = sum_abs[W:0];
    add_ovf = (sum_raw > SMAX) || (sum_raw < SMIN);
    if (sum_raw > SMAX)      add_val = WMAX;
    else if (sum_raw < SMIN) add_val = WMIN;
    else                     add_val = W'(sum_raw);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (guess_valid) state_next = S_SQ_LD;
      S_SQ_LD:   state_next = S_SQ_MUL;
      S_SQ_MUL:  if (cnt == CNTW'(NCH-1)) state_next = S_SQ_FIN;
      S_SQ_FIN:  state_next = S_CU_LD;
      S_CU_LD:   state_next = S_CU_MUL;
      S_CU_MUL:  if (cnt == CNTW'(NCH-1)) state_next = S_CU_FIN;
      S_CU_FIN:  state_next = S_CU_SUB1;
      S_CU_SUB1: state_next = S_CU_SUB2;
      S_CU_SUB2: state_next = S_CU_SUB3;
      S_CU_SUB3: state_next = first ? S_SL_ADD1 : S_EV_CHK;
      S_SL_ADD1: state_next = S_SL_ADD2;
      S_SL_ADD2: state_next = S_SL_SUB;
      S_SL_SUB:  if (cnt == CNTW'(3)) state_next = S_SL_CHK;
      S_SL_CHK:  state_next = (ovf || tacc == '0) ? S_DONE : S_DIV;
      S_DIV:     if (cnt == CNTW'(DW-1)) state_next = S_DIV_FIN;
      S_DIV_FIN: state_next = S_NXT;
      S_NXT:     state_next = S_SQ_LD;
      S_EV_CHK:  state_next = (ovf || res == '0) ? S_DONE : S_TOL_MUL;
      S_TOL_MUL: if (cnt == CNTW'(NCH-1)) state_next = S_TOL_CHK;
      S_TOL_CHK: begin
        state_next = (conv_hit || iter >= max_iterations) ? S_DONE : S_SL_ADD1;
      end
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    guess_stall = (state != S_IDLE);
    cfg_ready   = 1'b1;
  end

  // Control state, result valid and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      tolerance      <= TOL_RESET;
      max_iterations <= MAXIT_RESET;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) result_valid <= 1'b1;
      else if (!result_stall)          result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TOLERANCE: tolerance      <= cfg_data[TOL_W-1:0];
          CFG_MAX_ITER:  max_iterations <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (guess_valid) begin
          cur   <= clamp_in(initial_guess);
          nxt   <= clamp_in(initial_guess);
          ovf   <= 1'b0;
          first <= 1'b1;
          iter  <= ITER_W'(1);
        end
      end
      S_SQ_LD: begin
        ma   <= magw(nxt);
        mb   <= MBW'(magw(nxt));
        acc  <= '0;
        cnt  <= '0;
        mneg <= 1'b0;
      end
      S_CU_LD: begin
        ma   <= magw(x2);
        mb   <= MBW'(magw(nxt));
        acc  <= '0;
        cnt  <= '0;
        mneg <= nxt[W-1];
      end
      S_SQ_MUL, S_CU_MUL, S_TOL_MUL: begin
        acc <= mul_acc;
        mb  <= mb << 16;
        cnt <= cnt + CNTW'(1);
      end
      S_SQ_FIN: begin
        x2  <= conv_out[W-1:0];
        ovf <= ovf | conv_out[W];
      end
      S_CU_FIN, S_DIV_FIN: begin
        tacc <= conv_out[W-1:0];
        ovf  <= ovf | conv_out[W];
      end
      S_CU_SUB1, S_CU_SUB2, S_SL_ADD2: begin
        tacc <= add_val;
        ovf  <= ovf | add_ovf;
      end
      S_CU_SUB3: begin
        res <= add_val;
        ovf <= ovf | add_ovf;
      end
      S_SL_ADD1: begin
        tacc <= add_val;
        ovf  <= ovf | add_ovf;
        cnt  <= '0;
      end
      S_SL_SUB: begin
        tacc <= add_val;
        ovf  <= ovf | add_ovf;
        cnt  <= cnt + CNTW'(1);
      end
      // Load the divider with |f| << FRAC_BITS over |f'|
      S_SL_CHK: begin
        ma         <= magw(tacc);
        acc        <= PW'({magw(res), {F{1'b0}}});
        rem        <= '0;
        cnt        <= '0;
        mneg       <= res[W-1] ^ tacc[W-1];
        fin_status <= ovf ? STAT_OVERFLOW : STAT_ZERO_SLOPE;
      end
      S_DIV: begin
        rem <= rem_next;
        acc <= PW'({acc[DW-2:0], qbit});
        cnt <= cnt + CNTW'(1);
      end
      S_NXT: begin
        nxt   <= add_val;
        ovf   <= ovf | add_ovf;
        first <= 1'b0;
      end
      // Latch the step size and start tolerance * |nxt|
      S_EV_CHK: begin
        fin_status <= ovf ? STAT_OVERFLOW : STAT_CONVERGED;
        dmag       <= add_mag;
        ma         <= magw(nxt);
        mb         <= MBW'(tolerance);
        acc        <= '0;
        cnt        <= '0;
      end
      // Stop or advance to the next iterate
      S_TOL_CHK: begin
        fin_status <= conv_hit ? STAT_CONVERGED : STAT_LIMIT;
        if (!conv_hit && iter < max_iterations) begin
          iter <= iter + ITER_W'(1);
          cur  <= nxt;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      root       <= clamp_out(nxt);
      residual   <= clamp_out(res);
      iterations <= iter;
      status     <= fin_status;
    end
  end

  // A new result only comes out of the final state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the final state");

  // The iteration count starts at one for every search
  a_iter_nonzero: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> iter != '0)
    else $error("iteration count is zero during a search");

  // Divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < ma)
    else $error("divider remainder not below divisor");

  // The tolerance product is only formed on an overflow-free iterate
  a_tol_no_ovf: assert property (@(posedge clk) disable iff (rst)
    state == S_TOL_MUL |-> !ovf)
    else $error("tolerance test reached with overflow pending");

endmodule
